// ===== src/p1305_pkg.sv =====
`default_nettype none
package p1305_pkg;

   localparam int LIMB_W = 26;
   localparam int H_W    = 32;
   localparam int NLIMBS = 5;

   localparam logic [H_W-1:0] LIMB_MASK  = 32'h03ff_ffff;
   localparam logic [H_W-1:0] HIBIT_FULL = 32'h0100_0000;
   localparam logic [H_W-1:0] P_TOP      = 32'h0400_0000;

   localparam logic [1:0] CSR_R_LOW  = 2'd0;
   localparam logic [1:0] CSR_R_HIGH = 2'd1;
   localparam logic [1:0] CSR_S_LOW  = 2'd2;
   localparam logic [1:0] CSR_S_HIGH = 2'd3;

   typedef struct packed {
      logic       load;
      logic       row;
      logic [2:0] row_idx;
      logic       fold;
      logic       norm;
      logic       sel;
      logic       emit;
   } p1305_cmd_type;

   typedef struct packed {
      logic req_absorb;
      logic req_last;
      logic out_full;
   } p1305_status_type;

endpackage
`default_nettype wire

// ===== src/p1305_if.sv =====
`default_nettype none
interface p1305_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] block_low;
   logic [63:0] block_high;
   logic [4:0]  byte_count;
   logic        last_block;
   modport source (output valid, block_low, block_high, byte_count, last_block, input ready);
   modport sink (input valid, block_low, block_high, byte_count, last_block, output ready);
endinterface

interface p1305_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] tag_low;
   logic [63:0] tag_high;
   modport source (output valid, tag_low, tag_high, input ready);
   modport sink (input valid, tag_low, tag_high, output ready);
endinterface
`default_nettype wire

// ===== src/p1305_ctrl.sv =====
`default_nettype none
module p1305_ctrl
   import p1305_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire p1305_status_type status,
   output p1305_cmd_type         cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_ROW  = 3'd1;
   localparam logic [2:0] S_FOLD = 3'd2;
   localparam logic [2:0] S_NORM = 3'd3;
   localparam logic [2:0] S_SEL  = 3'd4;
   localparam logic [2:0] S_EMIT = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [2:0] row_ff, row_in;
   logic       last_ff, last_in;

   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      last_in   = last_ff;
      cmd       = '0;
      cmd.row_idx = row_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               last_in  = status.req_last;
               row_in   = 3'd0;
               if (status.req_absorb) state_in = S_ROW;
               else if (status.req_last) state_in = S_NORM;
            end
         end
         S_ROW: begin
            cmd.row = 1'b1;
            if (row_ff == 3'(NLIMBS - 1)) state_in = S_FOLD;
            else row_in = row_ff + 3'd1;
         end
         S_FOLD: begin
            cmd.fold = 1'b1;
            state_in = last_ff ? S_NORM : S_IDLE;
         end
         S_NORM: begin
            cmd.norm = 1'b1;
            state_in = S_SEL;
         end
         S_SEL: begin
            cmd.sel  = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            // hold until the previous tag has been taken
            if (!status.out_full) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         row_ff   <= 3'd0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         last_ff  <= last_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/p1305_dp.sv =====
`default_nettype none
module p1305_dp
   import p1305_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_write_enable,
   input  wire logic [1:0]    csr_index,
   input  wire logic [63:0]   csr_write_data,
   input  wire logic [63:0]   block_low,
   input  wire logic [63:0]   block_high,
   input  wire logic [4:0]    byte_count,
   input  wire logic          last_block,
   input  wire p1305_cmd_type cmd,
   output p1305_status_type   status,
   input  wire logic          rsp_ready,
   output logic               rsp_valid,
   output logic [63:0]        tag_low,
   output logic [63:0]        tag_high
);

   logic [63:0] r_lo_ff, r_hi_ff, s_lo_ff, s_hi_ff;
   logic [H_W-1:0] h_ff [NLIMBS];
   logic [H_W-1:0] h_in [NLIMBS];
   logic [H_W-1:0] hs_ff [NLIMBS];
   logic [H_W-1:0] carry_ff, carry_in;
   logic [127:0] tag_ff, tag_in;
   logic out_full_ff, out_full_in;

   logic [25:0] r [NLIMBS];
   logic [28:0] s5 [NLIMBS];
   logic [127:0] blk_raw;
   logic [127:0] blk;
   logic [H_W-1:0] blk_limb [NLIMBS];
   logic [63:0] dsum;
   logic [28:0] coef [NLIMBS];
   logic [H_W-1:0] t [NLIMBS];
   logic [H_W-1:0] g [NLIMBS];
   logic [H_W-1:0] c;
   logic [63:0] pa, pb;
   logic [3:0] kk;

   // clamped r and 5*r
   always_comb begin
      r[0] = r_lo_ff[25:0];
      r[1] = r_lo_ff[51:26] & 26'h3ffff03;
      r[2] = {r_hi_ff[13:0], r_lo_ff[63:52]} & 26'h3ffc0ff;
      r[3] = r_hi_ff[39:14] & 26'h3f03fff;
      r[4] = {2'b00, r_hi_ff[63:40]} & 26'h00fffff;
      for (int i = 0; i < NLIMBS; i++) s5[i] = 29'(r[i]) * 29'd5;
   end

   assign blk_raw = {block_high, block_low};

   // pad: keep bytes below count, 0x01 at count
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         if (byte_count >= 5'd16 || 5'(i) < byte_count)
            blk[i*8 +: 8] = blk_raw[i*8 +: 8];
         else if (5'(i) == byte_count)
            blk[i*8 +: 8] = 8'h01;
         else
            blk[i*8 +: 8] = 8'h00;
      end
      blk_limb[0] = {6'd0, blk[25:0]};
      blk_limb[1] = {6'd0, blk[51:26]};
      blk_limb[2] = {6'd0, blk[77:52]};
      blk_limb[3] = {6'd0, blk[103:78]};
      blk_limb[4] = {8'd0, blk[127:104]} | ((byte_count >= 5'd16) ? HIBIT_FULL : '0);
   end

   assign status.req_absorb = (byte_count != 5'd0);
   assign status.req_last   = last_block;
   assign status.out_full   = out_full_ff;

   // one row of the limb product
   always_comb begin
      for (int j = 0; j < NLIMBS; j++) begin
         kk = {1'b0, cmd.row_idx} + 4'(NLIMBS) - 4'(j);
         if (kk >= 4'(NLIMBS)) kk = kk - 4'(NLIMBS);
         coef[j] = (3'(j) <= cmd.row_idx) ? {3'd0, r[kk[2:0]]} : s5[kk[2:0]];
      end
      dsum = {32'd0, carry_ff};
      for (int j = 0; j < NLIMBS; j++)
         dsum = dsum + 64'(hs_ff[j]) * 64'(coef[j]);
   end

   always_comb begin
      for (int i = 0; i < NLIMBS; i++) h_in[i] = h_ff[i];
      carry_in    = carry_ff;
      tag_in      = tag_ff;
      out_full_in = out_full_ff && !rsp_ready;
      for (int i = 0; i < NLIMBS; i++) begin
         t[i] = '0;
         g[i] = '0;
      end
      c  = '0;
      pa = '0;
      pb = '0;
      if (cmd.load) carry_in = '0;
      if (cmd.row) begin
         h_in[cmd.row_idx] = {6'd0, dsum[25:0]};
         carry_in          = dsum[57:26];
      end
      if (cmd.fold) begin
         t[0] = h_ff[0] + carry_ff * 32'd5;
         c = t[0] >> 26;
         h_in[0] = t[0] & LIMB_MASK;
         h_in[1] = h_ff[1] + c;
      end
      if (cmd.norm) begin
         c = h_ff[1] >> 26; t[1] = h_ff[1] & LIMB_MASK; t[2] = h_ff[2] + c;
         c = t[2] >> 26;    t[2] = t[2] & LIMB_MASK;    t[3] = h_ff[3] + c;
         c = t[3] >> 26;    t[3] = t[3] & LIMB_MASK;    t[4] = h_ff[4] + c;
         c = t[4] >> 26;    t[4] = t[4] & LIMB_MASK;    t[0] = h_ff[0] + c * 32'd5;
         c = t[0] >> 26;    t[0] = t[0] & LIMB_MASK;    t[1] = t[1] + c;
         for (int i = 0; i < NLIMBS; i++) h_in[i] = t[i];
      end
      if (cmd.sel) begin
         g[0] = h_ff[0] + 32'd5; c = g[0] >> 26; g[0] = g[0] & LIMB_MASK;
         g[1] = h_ff[1] + c;     c = g[1] >> 26; g[1] = g[1] & LIMB_MASK;
         g[2] = h_ff[2] + c;     c = g[2] >> 26; g[2] = g[2] & LIMB_MASK;
         g[3] = h_ff[3] + c;     c = g[3] >> 26; g[3] = g[3] & LIMB_MASK;
         g[4] = h_ff[4] + c - P_TOP;
         // g4 non-negative means h >= p
         if (!g[4][H_W-1])
            for (int i = 0; i < NLIMBS; i++) h_in[i] = g[i];
      end
      if (cmd.emit) begin
         pa = 64'(h_ff[0]) | (64'(h_ff[1]) << 26) | (64'(h_ff[2]) << 52);
         pb = (64'(h_ff[2]) >> 12) | (64'(h_ff[3]) << 14) | (64'(h_ff[4] & LIMB_MASK) << 40);
         tag_in      = {pb, pa} + {s_hi_ff, s_lo_ff};
         out_full_in = 1'b1;
         for (int i = 0; i < NLIMBS; i++) h_in[i] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_lo_ff     <= '0;
         r_hi_ff     <= '0;
         s_lo_ff     <= '0;
         s_hi_ff     <= '0;
         out_full_ff <= 1'b0;
         carry_ff    <= '0;
         for (int i = 0; i < NLIMBS; i++) h_ff[i] <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_R_LOW:  r_lo_ff <= csr_write_data;
               CSR_R_HIGH: r_hi_ff <= csr_write_data;
               CSR_S_LOW:  s_lo_ff <= csr_write_data;
               CSR_S_HIGH: s_hi_ff <= csr_write_data;
               default: ;
            endcase
         end
         out_full_ff <= out_full_in;
         carry_ff    <= carry_in;
         for (int i = 0; i < NLIMBS; i++) h_ff[i] <= h_in[i];
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
      if (cmd.load)
         for (int i = 0; i < NLIMBS; i++) hs_ff[i] <= h_ff[i] + blk_limb[i];
   end

   assign rsp_valid = out_full_ff;
   assign tag_low   = tag_ff[63:0];
   assign tag_high  = tag_ff[127:64];

endmodule
`default_nettype wire

// ===== src/poly1305_mac_engine_core.sv =====
`default_nettype none
// channel | dir | handshake   | payload
// req     | in  | valid/ready | block_low, block_high, byte_count, last_block
// rsp     | out | valid/ready | tag_low, tag_high
// csr     | in  | write enable| csr_index, csr_write_data
// A block with data runs load, five product rows (one limb row of the 5x5
// limb multiply each) and carry fold. A last block adds final reduction
// and tag add. Synchronous reset clears key and accumulator.
// The tag waits in an output register; a new request is taken meanwhile, and
// the engine stalls before writing the next tag until the old one is taken.
module poly1305_mac_engine_core
   import p1305_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   p1305_req_if.sink        req,
   p1305_rsp_if.source      rsp,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_write_data
);

   p1305_cmd_type    cmd;
   p1305_status_type status;

   p1305_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   p1305_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .block_low        (req.block_low),
      .block_high       (req.block_high),
      .byte_count       (req.byte_count),
      .last_block       (req.last_block),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp.ready),
      .rsp_valid        (rsp.valid),
      .tag_low          (rsp.tag_low),
      .tag_high         (rsp.tag_high)
   );

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
module tb_top;
   import p1305_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [63:0] block_low;
      logic [63:0] block_high;
      logic [4:0]  byte_count;
      logic        last_block;
   } block_req_type;

   typedef struct packed {
      logic [63:0] tag_low;
      logic [63:0] tag_high;
   } tag_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = CSR_R_LOW;
   logic [63:0] csr_write_data = '0;

   p1305_req_if req_ch();
   p1305_rsp_if rsp_ch();

   poly1305_mac_engine_core DUT (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model state
   logic [63:0] key_r_lo = '0, key_r_hi = '0, key_s_lo = '0, key_s_hi = '0;
   logic [31:0] acc [5] = '{default: '0};

   block_req_type pending_reqs[$];
   tag_type       expected_tags[$];
   int            error_count = 0;
   bit            driver_idle_en = 1'b1;
   bit            sink_idle_en = 1'b1;
   bit            sink_hold = 1'b0;

   function automatic void absorb_block(logic [63:0] lo, logic [63:0] hi, logic [31:0] hibit);
      logic [31:0] r0, r1, r2, r3, r4, s1, s2, s3, s4, c;
      logic [63:0] d0, d1, d2, d3, d4, t;
      r0 = 32'(key_r_lo[25:0]);
      r1 = 32'(key_r_lo >> 26) & 32'h3ffff03;
      t = (key_r_lo >> 52) | (key_r_hi << 12);
      r2 = 32'(t) & 32'h3ffc0ff;
      r3 = 32'(key_r_hi >> 14) & 32'h3f03fff;
      r4 = 32'(key_r_hi >> 40) & 32'h00fffff;
      s1 = r1 * 5; s2 = r2 * 5; s3 = r3 * 5; s4 = r4 * 5;
      acc[0] += 32'(lo) & LIMB_MASK;
      acc[1] += 32'(lo >> 26) & LIMB_MASK;
      acc[2] += 32'((lo >> 52) | (hi << 12)) & LIMB_MASK;
      acc[3] += 32'(hi >> 14) & LIMB_MASK;
      acc[4] += 32'(hi >> 40) | hibit;
      d0 = 64'(acc[0])*r0 + 64'(acc[1])*s4 + 64'(acc[2])*s3 + 64'(acc[3])*s2 + 64'(acc[4])*s1;
      d1 = 64'(acc[0])*r1 + 64'(acc[1])*r0 + 64'(acc[2])*s4 + 64'(acc[3])*s3 + 64'(acc[4])*s2;
      d2 = 64'(acc[0])*r2 + 64'(acc[1])*r1 + 64'(acc[2])*r0 + 64'(acc[3])*s4 + 64'(acc[4])*s3;
      d3 = 64'(acc[0])*r3 + 64'(acc[1])*r2 + 64'(acc[2])*r1 + 64'(acc[3])*r0 + 64'(acc[4])*s4;
      d4 = 64'(acc[0])*r4 + 64'(acc[1])*r3 + 64'(acc[2])*r2 + 64'(acc[3])*r1 + 64'(acc[4])*r0;
      c = 32'(d0 >> 26); acc[0] = 32'(d0) & LIMB_MASK; d1 += 64'(c);
      c = 32'(d1 >> 26); acc[1] = 32'(d1) & LIMB_MASK; d2 += 64'(c);
      c = 32'(d2 >> 26); acc[2] = 32'(d2) & LIMB_MASK; d3 += 64'(c);
      c = 32'(d3 >> 26); acc[3] = 32'(d3) & LIMB_MASK; d4 += 64'(c);
      c = 32'(d4 >> 26); acc[4] = 32'(d4) & LIMB_MASK; acc[0] += c * 5;
      c = acc[0] >> 26; acc[0] &= LIMB_MASK; acc[1] += c;
   endfunction

   function automatic tag_type finalize_tag();
      logic [31:0] h0, h1, h2, h3, h4, g0, g1, g2, g3, g4, c, sel;
      logic [63:0] a, b;
      tag_type t;
      h0 = acc[0]; h1 = acc[1]; h2 = acc[2]; h3 = acc[3]; h4 = acc[4];
      c = h1 >> 26; h1 &= LIMB_MASK; h2 += c;
      c = h2 >> 26; h2 &= LIMB_MASK; h3 += c;
      c = h3 >> 26; h3 &= LIMB_MASK; h4 += c;
      c = h4 >> 26; h4 &= LIMB_MASK; h0 += c * 5;
      c = h0 >> 26; h0 &= LIMB_MASK; h1 += c;
      g0 = h0 + 5; c = g0 >> 26; g0 &= LIMB_MASK;
      g1 = h1 + c; c = g1 >> 26; g1 &= LIMB_MASK;
      g2 = h2 + c; c = g2 >> 26; g2 &= LIMB_MASK;
      g3 = h3 + c; c = g3 >> 26; g3 &= LIMB_MASK;
      g4 = h4 + c - P_TOP;
      sel = (g4 >> 31) - 1;
      h0 = (h0 & ~sel) | (g0 & sel);
      h1 = (h1 & ~sel) | (g1 & sel);
      h2 = (h2 & ~sel) | (g2 & sel);
      h3 = (h3 & ~sel) | (g3 & sel);
      h4 = (h4 & ~sel) | (g4 & sel);
      a = 64'(h0) | (64'(h1) << 26) | (64'(h2) << 52);
      b = (64'(h2) >> 12) | (64'(h3) << 14) | (64'(h4 & LIMB_MASK) << 40);
      t.tag_low = a + key_s_lo;
      t.tag_high = b + key_s_hi + ((t.tag_low < a) ? 64'd1 : 64'd0);
      return t;
   endfunction

   function automatic void predict_tag(block_req_type r);
      logic [63:0] lo, hi;
      int sh;
      lo = r.block_low; hi = r.block_high;
      if (r.byte_count >= 16) begin
         absorb_block(lo, hi, HIBIT_FULL);
      end else if (r.byte_count > 0) begin
         if (r.byte_count < 8) begin
            sh = 8 * r.byte_count;
            lo = (lo & ((64'd1 << sh) - 1)) | (64'd1 << sh);
            hi = '0;
         end else begin
            sh = 8 * (r.byte_count - 8);
            hi = (hi & ((64'd1 << sh) - 1)) | (64'd1 << sh);
         end
         absorb_block(lo, hi, 32'd0);
      end
      if (r.last_block) begin
         expected_tags.push_back(finalize_tag());
         acc = '{default: '0};
      end
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // driver
   initial begin
      req_ch.valid = 1'b0;
      req_ch.block_low = '0;
      req_ch.block_high = '0;
      req_ch.byte_count = '0;
      req_ch.last_block = 1'b0;
      rsp_ch.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_tag({req_ch.block_low, req_ch.block_high,
                         req_ch.byte_count, req_ch.last_block});
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_reqs.size() > 0 &&
                !(driver_idle_en && $urandom_range(99) < 18)) begin
               block_req_type n;
               n = pending_reqs.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.block_low <= n.block_low;
               req_ch.block_high <= n.block_high;
               req_ch.byte_count <= n.byte_count;
               req_ch.last_block <= n.last_block;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_tags.size() == 0) begin
               report_mismatch("unexpected tag_low", rsp_ch.tag_low, '0);
            end else begin
               tag_type e;
               e = expected_tags.pop_front();
               if (rsp_ch.tag_low !== e.tag_low)
                  report_mismatch("tag_low", rsp_ch.tag_low, e.tag_low);
               if (rsp_ch.tag_high !== e.tag_high)
                  report_mismatch("tag_high", rsp_ch.tag_high, e.tag_high);
            end
         end
         if (sink_hold) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !(sink_idle_en && $urandom_range(99) < 18);
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] rand_edge64();
      case ($urandom_range(3))
         0: return '0;
         1: return '1;
         default: return rand64();
      endcase
   endfunction

   function automatic void add_req(logic [63:0] lo, logic [63:0] hi, int cnt, bit last);
      block_req_type r;
      r.block_low = lo; r.block_high = hi;
      r.byte_count = 5'(cnt); r.last_block = last;
      pending_reqs.push_back(r);
   endfunction

   // random message: mostly full blocks, then a final one of any count
   function automatic int add_message();
      int nblk, n, c;
      nblk = $urandom_range(9);
      n = 0;
      for (int i = 0; i < nblk; i++) begin
         c = ($urandom_range(99) < 75) ? 16 : $urandom_range(31);
         add_req(rand64(), rand64(), c, 1'b0);
         n++;
      end
      add_req(rand64(), rand64(), $urandom_range(31), 1'b1);
      return n + 1;
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_ch.valid || expected_tags.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [63:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      case (idx)
         CSR_R_LOW:  key_r_lo = val;
         CSR_R_HIGH: key_r_hi = val;
         CSR_S_LOW:  key_s_lo = val;
         default:    key_s_hi = val;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic load_key(logic [63:0] rl, logic [63:0] rh, logic [63:0] sl, logic [63:0] sh);
      write_csr(CSR_R_LOW, rl);
      write_csr(CSR_R_HIGH, rh);
      write_csr(CSR_S_LOW, sl);
      write_csr(CSR_S_HIGH, sh);
   endtask

   initial begin
      int items;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty message with zero key, then tag = s
      add_req('0, '0, 0, 1'b1);
      wait_drained();
      load_key('1, '1, '1, '1);
      add_req('0, '0, 0, 1'b1);
      add_req('1, '1, 16, 1'b1);
      for (int c = 1; c <= 16; c++) add_req('1, '1, c, c == 16);
      add_req('1, '1, 31, 1'b0);
      add_req(64'h0123456789abcdef, 64'hfedcba9876543210, 17, 1'b0);
      add_req('1, '0, 0, 1'b1);
      wait_drained();
      // fixed key with a full block and a one-byte last block
      load_key(64'h33085d0655ddd585, 64'h01bf42d803a8fe80,
               64'h4a8eb2a15fcdb1f5, 64'h6b5c1e3c0dd3fd5d);
      add_req(64'h6172676f74706572, 64'h2063696870617247, 16, 1'b0);
      add_req(64'h0000000000000000, 64'h0000000000000000, 1, 1'b1);
      wait_drained();

      items = 0;
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 5) load_key('0, '0, '0, '0);
         else load_key(rand_edge64(), rand_edge64(), rand_edge64(), rand_edge64());
         driver_idle_en = (phase != 2);
         sink_idle_en = (phase != 2);
         if (phase == 3) begin
            // receiver holds off while requests keep coming
            fork
               begin
                  sink_hold = 1'b1;
                  repeat (300) @(posedge clock);
                  sink_hold = 1'b0;
               end
            join_none
         end
         while (items < (phase + 1) * 255) items += add_message();
         // sender pauses until every tag is back
         wait_drained();
      end

      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("CHECK FAILED");
      $finish;
   end
endmodule

// ===== files.f =====
src/p1305_pkg.sv
src/p1305_if.sv
src/p1305_ctrl.sv
src/p1305_dp.sv
src/poly1305_mac_engine_core.sv
verif/tb_top.sv
